[src/cts_pkg.sv]
// ----------------------------------------------------------------------------
// cts_pkg: shared types and character class helpers
// Scan modes, held-symbol kinds, token classes and range tests for the
// code point token segmenter.
// ----------------------------------------------------------------------------
`default_nettype none

package cts_pkg;

	localparam int unsigned CpW = 21;

	typedef logic [CpW-1:0] cp_t;

	typedef enum logic [2:0] {
		MODE_IDLE  = 3'd0,
		MODE_HAN   = 3'd1,
		MODE_INT   = 3'd2,
		MODE_FRAC  = 3'd3,
		MODE_ALPHA = 3'd4
	} mode_t;

	typedef enum logic [1:0] {
		HELD_NONE = 2'd0,
		HELD_SIGN = 2'd1,
		HELD_SEP  = 2'd2
	} held_t;

	typedef enum logic [1:0] {
		CLS_SKIP  = 2'd0,
		CLS_HAN   = 2'd1,
		CLS_NUM   = 2'd2,
		CLS_ALPHA = 2'd3
	} cls_t;

	typedef struct packed {
		cp_t  symbol;
		cls_t token_class;
		logic token_start;
		logic run_last;
		logic text_done;
	} res_t;

	localparam cp_t CP_PLUS  = 21'h00002B;
	localparam cp_t CP_MINUS = 21'h00002D;
	localparam cp_t CP_DOT   = 21'h00002E;
	localparam cp_t CP_COMMA = 21'h00002C;
	localparam cp_t CP_UNDER = 21'h00005F;

	function automatic logic in_rng(input cp_t c, input cp_t lo, input cp_t hi);
		return (c >= lo) && (c <= hi);
	endfunction

	function automatic logic is_han(input cp_t c);
		return in_rng(c, 21'h04E00, 21'h09FFF) || in_rng(c, 21'h03400, 21'h04DBF) ||
			in_rng(c, 21'h20000, 21'h2A6DF) || in_rng(c, 21'h2A700, 21'h2B73F) ||
			in_rng(c, 21'h2B740, 21'h2B81F) || in_rng(c, 21'h2B820, 21'h2CEAF) ||
			in_rng(c, 21'h0F900, 21'h0FAFF) || in_rng(c, 21'h2F800, 21'h2FA1F);
	endfunction

	function automatic logic is_digit(input cp_t c);
		return in_rng(c, 21'h00030, 21'h00039) || in_rng(c, 21'h0FF10, 21'h0FF19);
	endfunction

	function automatic logic is_letter(input cp_t c);
		return in_rng(c, 21'h00041, 21'h0005A) || in_rng(c, 21'h00061, 21'h0007A);
	endfunction

endpackage

`default_nettype wire

[src/cts_in_if.sv]
// ----------------------------------------------------------------------------
// cts_in_if: code point input channel
// Valid/ready channel carrying one code point and its end-of-text mark.
// ----------------------------------------------------------------------------
`default_nettype none

interface cts_in_if;
	logic                     valid;
	logic                     ready;
	logic [cts_pkg::CpW-1:0]  code_point;
	logic                     end_of_text;

	modport source (output valid, output code_point, output end_of_text, input ready);
	modport sink   (input valid, input code_point, input end_of_text, output ready);
endinterface

`default_nettype wire

[src/cts_out_if.sv]
// ----------------------------------------------------------------------------
// cts_out_if: token label output channel
// Valid/ready channel carrying one labelled code point.
// ----------------------------------------------------------------------------
`default_nettype none

interface cts_out_if;
	logic                     valid;
	logic                     ready;
	logic [cts_pkg::CpW-1:0]  symbol;
	logic [1:0]               token_class;
	logic                     token_start;
	logic                     run_last;
	logic                     text_done;

	modport source (output valid, output symbol, output token_class, output token_start,
		output run_last, output text_done, input ready);
	modport sink   (input valid, input symbol, input token_class, input token_start,
		input run_last, input text_done, output ready);
endinterface

`default_nettype wire

[src/codepoint_token_segmenter.sv]
// ----------------------------------------------------------------------------
// codepoint_token_segmenter: labels code points with token class and start
// Han runs, numbers (sign, digits, underscores, one fraction) and ASCII letter
// runs; a sign or separator is held until the next code point decides it.
// ----------------------------------------------------------------------------
//  channel   dir  payload                                         per request
//  text      in   code_point, end_of_text                         one code point
//  labels    out  symbol, token_class, token_start, run_last,     one label
//                 text_done
//
//  Input register, then classify into a two-entry result register.
//  One code point per cycle while each yields at most one label and labels
//  is ready; one yielding two labels holds the result register, and so the
//  input, until its second label is taken on the output port.
//  Reset clears the scan mode, the held kind and all valid/count state.
//  A stall on labels backs up into text.ready with no loss.
// ----------------------------------------------------------------------------
`default_nettype none

module codepoint_token_segmenter (
	input  wire logic  clk,
	input  wire logic  arst_n,
	cts_in_if.sink     text,
	cts_out_if.source  labels
);
	import cts_pkg::*;

	// input register
	logic  valid_s1;
	cp_t   cp_s1;
	logic  eot_s1;

	// scan state
	mode_t mode_q;
	held_t held_q;
	cp_t   held_sym_q;

	// result register
	res_t        r0_q, r1_q;
	logic [1:0]  cnt_q;

	logic  s1_go;
	logic  pop;

	res_t        res [2];
	logic [1:0]  n_res;
	mode_t       mode_d;
	held_t       held_d;
	cp_t         held_sym_d;

	assign pop   = labels.valid && labels.ready;
	assign s1_go = valid_s1 && ((cnt_q == 2'd0) || ((cnt_q == 2'd1) && labels.ready));
	assign text.ready = !valid_s1 || s1_go;

	always_comb begin
		mode_t cur;
		logic  consumed;
		logic  emit_c;
		logic  hold_c;
		held_t hold_kind;
		res_t  lab;
		mode_t cmode;

		res[0]     = '0;
		res[1]     = '0;
		n_res      = 2'd0;
		mode_d     = mode_q;
		held_d     = HELD_NONE;
		held_sym_d = held_sym_q;
		cur        = mode_q;
		consumed   = 1'b0;
		emit_c     = 1'b0;
		hold_c     = 1'b0;
		hold_kind  = HELD_NONE;
		lab        = '0;
		cmode      = mode_q;

		lab.symbol = cp_s1;

		case (held_q)
			HELD_SIGN, HELD_SEP: begin
				res[0].symbol = held_sym_q;
				if (is_digit(cp_s1)) begin
					res[0].token_class = CLS_NUM;
					res[0].token_start = (held_q == HELD_SIGN);
					res[1].symbol      = cp_s1;
					res[1].token_class = CLS_NUM;
					n_res    = 2'd2;
					mode_d   = (held_q == HELD_SIGN) ? MODE_INT : MODE_FRAC;
					consumed = 1'b1;
				end else begin
					res[0].token_class = CLS_SKIP;
					n_res = 2'd1;
					cur   = MODE_IDLE;
				end
			end
			default: ;
		endcase

		// continue the current token, else start afresh
		cmode = cur;
		if (cur == MODE_HAN && is_han(cp_s1)) begin
			emit_c = 1'b1; lab.token_class = CLS_HAN;
		end else if (cur == MODE_INT && (is_digit(cp_s1) || cp_s1 == CP_UNDER)) begin
			emit_c = 1'b1; lab.token_class = CLS_NUM;
		end else if (cur == MODE_INT && (cp_s1 == CP_DOT || cp_s1 == CP_COMMA)) begin
			hold_c = 1'b1; hold_kind = HELD_SEP;
		end else if (cur == MODE_FRAC && is_digit(cp_s1)) begin
			emit_c = 1'b1; lab.token_class = CLS_NUM;
		end else if (cur == MODE_ALPHA && is_letter(cp_s1)) begin
			emit_c = 1'b1; lab.token_class = CLS_ALPHA;
		end else if (is_han(cp_s1)) begin
			emit_c = 1'b1; lab.token_class = CLS_HAN; lab.token_start = 1'b1;
			cmode = MODE_HAN;
		end else if (is_digit(cp_s1)) begin
			emit_c = 1'b1; lab.token_class = CLS_NUM; lab.token_start = 1'b1;
			cmode = MODE_INT;
		end else if (cp_s1 == CP_PLUS || cp_s1 == CP_MINUS) begin
			hold_c = 1'b1; hold_kind = HELD_SIGN;
			cmode = MODE_IDLE;
		end else if (is_letter(cp_s1)) begin
			emit_c = 1'b1; lab.token_class = CLS_ALPHA; lab.token_start = 1'b1;
			cmode = MODE_ALPHA;
		end else begin
			emit_c = 1'b1; lab.token_class = CLS_SKIP;
			cmode = MODE_IDLE;
		end

		if (!consumed) begin
			mode_d = cmode;
			if (emit_c) begin
				res[n_res[0]] = lab;
				n_res = n_res + 2'd1;
			end
			if (hold_c) begin
				held_d     = hold_kind;
				held_sym_d = cp_s1;
			end
		end

		// end of text flushes a fresh hold as skipped
		if (eot_s1) begin
			if (held_d != HELD_NONE) begin
				res[n_res[0]]        = '0;
				res[n_res[0]].symbol = held_sym_d;
				n_res = n_res + 2'd1;
			end
			held_d = HELD_NONE;
			mode_d = MODE_IDLE;
		end

		if (n_res == 2'd2) begin
			res[1].run_last  = 1'b1;
			res[1].text_done = eot_s1;
		end else if (n_res == 2'd1) begin
			res[0].run_last  = 1'b1;
			res[0].text_done = eot_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text.valid && text.ready) begin
			valid_s1 <= 1'b1;
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (text.valid && text.ready) begin
			cp_s1  <= text.code_point;
			eot_s1 <= text.end_of_text;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			held_q <= HELD_NONE;
		end else if (s1_go) begin
			mode_q <= mode_d;
			held_q <= held_d;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			held_sym_q <= held_sym_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (s1_go) begin
			cnt_q <= n_res;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			r0_q <= res[0];
			r1_q <= res[1];
		end else if (pop) begin
			r0_q <= r1_q;
		end
	end

	assign labels.valid       = (cnt_q != 2'd0);
	assign labels.symbol      = r0_q.symbol;
	assign labels.token_class = r0_q.token_class;
	assign labels.token_start = r0_q.token_start;
	assign labels.run_last    = r0_q.run_last;
	assign labels.text_done   = r0_q.text_done;

	a_start_has_class: assert property (@(posedge clk) disable iff (!arst_n)
		labels.valid && labels.token_start |-> labels.token_class != CLS_SKIP)
		else $error("token start on skipped label");

	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		labels.valid && labels.text_done |-> labels.run_last)
		else $error("text done without run last");

	a_eot_clears: assert property (@(posedge clk) disable iff (!arst_n)
		s1_go && eot_s1 |=> mode_q == MODE_IDLE && held_q == HELD_NONE)
		else $error("state not cleared at end of text");

	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd2 |-> !r0_q.run_last && r1_q.run_last)
		else $error("run last misplaced in label pair");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("result register overflow");

endmodule

`default_nettype wire

[tb/tb_codepoint_token_segmenter.sv]
// ----------------------------------------------------------------------------
// tb_codepoint_token_segmenter: self-checking bench for the token segmenter
// Feeds texts of code points (Han runs, signed numbers with fractions, letter
// runs, whitespace and noise) through the text channel under varying idle and
// stall patterns, predicts every label and checks them in order on labels.
// ----------------------------------------------------------------------------

module tb_codepoint_token_segmenter;
	timeunit 1ns;
	timeprecision 1ps;

	import cts_pkg::*;

	localparam int  CycleLimit  = 400000;
	localparam int  PhaseItems  = 350;
	localparam int  MaxPrinted  = 40;
	localparam int  DrainCycles = 20;
	localparam cp_t CP_SPACE    = 21'h000020;
	localparam cp_t CP_TAB      = 21'h000009;
	localparam cp_t CP_LF       = 21'h00000A;
	localparam cp_t CP_IDEO_SP  = 21'h003000;

	typedef struct {
		cp_t  cp;
		logic eot;
	} text_req_t;

	logic clk = 1'b0;
	logic arst_n;

	cts_in_if  text ();
	cts_out_if labels ();

	codepoint_token_segmenter dut (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text),
		.labels (labels)
	);

	always #1 clk = ~clk;

	text_req_t text_reqs[$];
	res_t      due_labels[$];
	int        text_gap_pct    = 0;
	int        label_stall_pct = 0;
	int        mismatches      = 0;
	int        cycles          = 0;
	logic      text_fire       = 1'b0;

	// segmenter state as seen by the predictor
	mode_t scan_state = MODE_IDLE;
	cp_t   held_sym   = '0;
	held_t held_kind  = HELD_NONE;

	function automatic logic han_cp(input cp_t c);
		return (c >= 21'h04E00 && c <= 21'h09FFF) || (c >= 21'h03400 && c <= 21'h04DBF) ||
			(c >= 21'h20000 && c <= 21'h2A6DF) || (c >= 21'h2A700 && c <= 21'h2B73F) ||
			(c >= 21'h2B740 && c <= 21'h2B81F) || (c >= 21'h2B820 && c <= 21'h2CEAF) ||
			(c >= 21'h0F900 && c <= 21'h0FAFF) || (c >= 21'h2F800 && c <= 21'h2FA1F);
	endfunction

	function automatic logic digit_cp(input cp_t c);
		return (c >= 21'h30 && c <= 21'h39) || (c >= 21'h0FF10 && c <= 21'h0FF19);
	endfunction

	function automatic logic letter_cp(input cp_t c);
		return (c >= 21'h41 && c <= 21'h5A) || (c >= 21'h61 && c <= 21'h7A);
	endfunction

	function automatic res_t mk_label(input cp_t s, input cls_t k, input logic st);
		res_t r;
		r.symbol      = s;
		r.token_class = k;
		r.token_start = st;
		r.run_last    = 1'b0;
		r.text_done   = 1'b0;
		return r;
	endfunction

	// labels produced by one accepted code point, appended to due_labels
	task automatic predict_labels(input cp_t c, input logic eot);
		res_t  outs[$];
		held_t kind;
		logic  taken;
		taken = 1'b0;
		if (held_kind == HELD_SIGN || held_kind == HELD_SEP) begin
			kind = held_kind;
			held_kind = HELD_NONE;
			if (digit_cp(c)) begin
				outs.insert(outs.size(), mk_label(held_sym, CLS_NUM, kind == HELD_SIGN));
				outs.insert(outs.size(), mk_label(c, CLS_NUM, 1'b0));
				scan_state = (kind == HELD_SIGN) ? MODE_INT : MODE_FRAC;
				taken = 1'b1;
			end else begin
				outs.insert(outs.size(), mk_label(held_sym, CLS_SKIP, 1'b0));
				scan_state = MODE_IDLE;
			end
		end else begin
			held_kind = HELD_NONE;
		end
		if (!taken) begin
			if (scan_state == MODE_HAN && han_cp(c)) begin
				outs.insert(outs.size(), mk_label(c, CLS_HAN, 1'b0));
			end else if (scan_state == MODE_INT && (digit_cp(c) || c == CP_UNDER)) begin
				outs.insert(outs.size(), mk_label(c, CLS_NUM, 1'b0));
			end else if (scan_state == MODE_INT && (c == CP_DOT || c == CP_COMMA)) begin
				held_sym = c;
				held_kind = HELD_SEP;
			end else if (scan_state == MODE_FRAC && digit_cp(c)) begin
				outs.insert(outs.size(), mk_label(c, CLS_NUM, 1'b0));
			end else if (scan_state == MODE_ALPHA && letter_cp(c)) begin
				outs.insert(outs.size(), mk_label(c, CLS_ALPHA, 1'b0));
			end else if (han_cp(c)) begin
				outs.insert(outs.size(), mk_label(c, CLS_HAN, 1'b1));
				scan_state = MODE_HAN;
			end else if (digit_cp(c)) begin
				outs.insert(outs.size(), mk_label(c, CLS_NUM, 1'b1));
				scan_state = MODE_INT;
			end else if (c == CP_PLUS || c == CP_MINUS) begin
				held_sym = c;
				held_kind = HELD_SIGN;
				scan_state = MODE_IDLE;
			end else if (letter_cp(c)) begin
				outs.insert(outs.size(), mk_label(c, CLS_ALPHA, 1'b1));
				scan_state = MODE_ALPHA;
			end else begin
				outs.insert(outs.size(), mk_label(c, CLS_SKIP, 1'b0));
				scan_state = MODE_IDLE;
			end
		end
		// end of text flushes whatever is still held
		if (eot) begin
			if (held_kind != HELD_NONE)
				outs.insert(outs.size(), mk_label(held_sym, CLS_SKIP, 1'b0));
			held_kind = HELD_NONE;
			scan_state = MODE_IDLE;
		end
		if (outs.size() > 0) begin
			outs[$].run_last = 1'b1;
			outs[$].text_done = eot;
		end
		foreach (outs[i])
			due_labels.insert(due_labels.size(), outs[i]);
	endtask

	task automatic report_mismatch(input string msg);
		if (mismatches < MaxPrinted)
			$display("mismatch at cycle %0d: %s", cycles, msg);
		mismatches++;
	endtask

	task automatic check_label();
		res_t want;
		if (due_labels.size() == 0) begin
			report_mismatch($sformatf("label for %h with none expected", labels.symbol));
		end else begin
			want = due_labels.pop_front();
			if (labels.symbol !== want.symbol)
				report_mismatch($sformatf("symbol got %h want %h",
					labels.symbol, want.symbol));
			if (labels.token_class !== want.token_class)
				report_mismatch($sformatf("token_class of %h got %0d want %0d",
					want.symbol, labels.token_class, want.token_class));
			if (labels.token_start !== want.token_start)
				report_mismatch($sformatf("token_start of %h got %b want %b",
					want.symbol, labels.token_start, want.token_start));
			if (labels.run_last !== want.run_last)
				report_mismatch($sformatf("run_last of %h got %b want %b",
					want.symbol, labels.run_last, want.run_last));
			if (labels.text_done !== want.text_done)
				report_mismatch($sformatf("text_done of %h got %b want %b",
					want.symbol, labels.text_done, want.text_done));
		end
	endtask

	// monitor: both channels sampled at the rising edge
	always @(posedge clk) begin
		cycles++;
		text_fire = text.valid && text.ready;
		if (arst_n) begin
			if (labels.valid && labels.ready)
				check_label();
			if (text_fire)
				predict_labels(text.code_point, text.end_of_text);
		end
		if (cycles >= CycleLimit) begin
			$display("status: fail");
			$finish;
		end
	end

	// driver: requests and ready change at the falling edge
	always @(negedge clk) begin : drive_text
		text_req_t nxt;
		if (arst_n) begin
			if (!text.valid || text_fire) begin
				if (text_reqs.size() > 0 && $urandom_range(0, 99) >= text_gap_pct) begin
					nxt = text_reqs.pop_front();
					text.code_point  <= nxt.cp;
					text.end_of_text <= nxt.eot;
					text.valid       <= 1'b1;
				end else begin
					text.valid <= 1'b0;
				end
			end
			labels.ready <= ($urandom_range(0, 99) >= label_stall_pct);
		end
	end

	task automatic push_req(input cp_t c, input logic eot);
		text_req_t r;
		r.cp = c;
		r.eot = eot;
		text_reqs.insert(text_reqs.size(), r);
	endtask

	function automatic cp_t rand_han();
		case ($urandom_range(0, 7))
			0: return cp_t'($urandom_range(21'h04E00, 21'h09FFF));
			1: return cp_t'($urandom_range(21'h03400, 21'h04DBF));
			2: return cp_t'($urandom_range(21'h20000, 21'h2A6DF));
			3: return cp_t'($urandom_range(21'h2A700, 21'h2B73F));
			4: return cp_t'($urandom_range(21'h2B740, 21'h2B81F));
			5: return cp_t'($urandom_range(21'h2B820, 21'h2CEAF));
			6: return cp_t'($urandom_range(21'h0F900, 21'h0FAFF));
			default: return cp_t'($urandom_range(21'h2F800, 21'h2FA1F));
		endcase
	endfunction

	function automatic cp_t rand_digit();
		if ($urandom_range(0, 1))
			return cp_t'($urandom_range(21'h30, 21'h39));
		return cp_t'($urandom_range(21'h0FF10, 21'h0FF19));
	endfunction

	function automatic cp_t rand_letter();
		if ($urandom_range(0, 1))
			return cp_t'($urandom_range(21'h41, 21'h5A));
		return cp_t'($urandom_range(21'h61, 21'h7A));
	endfunction

	// a class boundary, or one off either side of it
	function automatic cp_t rand_edge();
		cp_t bound;
		case ($urandom_range(0, 23))
			0: bound = 21'h04E00;   1: bound = 21'h09FFF;
			2: bound = 21'h03400;   3: bound = 21'h04DBF;
			4: bound = 21'h20000;   5: bound = 21'h2A6DF;
			6: bound = 21'h2A700;   7: bound = 21'h2B73F;
			8: bound = 21'h2B740;   9: bound = 21'h2B81F;
			10: bound = 21'h2B820;  11: bound = 21'h2CEAF;
			12: bound = 21'h0F900;  13: bound = 21'h0FAFF;
			14: bound = 21'h2F800;  15: bound = 21'h2FA1F;
			16: bound = 21'h00030;  17: bound = 21'h00039;
			18: bound = 21'h0FF10;  19: bound = 21'h0FF19;
			20: bound = 21'h00041;  21: bound = 21'h0005A;
			22: bound = 21'h00061;  default: bound = 21'h0007A;
		endcase
		return bound + cp_t'($urandom_range(0, 2)) - cp_t'(1);
	endfunction

	function automatic cp_t rand_space();
		case ($urandom_range(0, 3))
			0: return CP_SPACE;
			1: return CP_TAB;
			2: return CP_LF;
			default: return CP_IDEO_SP;
		endcase
	endfunction

	// one text: a few tokens of random content, end_of_text on its last code point
	task automatic queue_text(inout int added);
		cp_t seq[$];
		int  ntok;
		int  len;
		ntok = $urandom_range(1, 6);
		repeat (ntok) begin
			case ($urandom_range(0, 9))
				0, 1: begin
					len = $urandom_range(1, 4);
					repeat (len) seq.insert(seq.size(), rand_han());
				end
				2, 3, 4: begin
					if ($urandom_range(0, 2) == 0)
						seq.insert(seq.size(), $urandom_range(0, 1) ? CP_PLUS : CP_MINUS);
					len = $urandom_range(1, 5);
					for (int i = 0; i < len; i++)
						seq.insert(seq.size(), (i > 0 && $urandom_range(0, 4) == 0) ?
							CP_UNDER : rand_digit());
					if ($urandom_range(0, 2) == 0) begin
						seq.insert(seq.size(), $urandom_range(0, 1) ? CP_DOT : CP_COMMA);
						len = $urandom_range(0, 3);
						repeat (len) seq.insert(seq.size(), rand_digit());
					end
				end
				5, 6: begin
					len = $urandom_range(1, 5);
					repeat (len) seq.insert(seq.size(), rand_letter());
				end
				7: seq.insert(seq.size(), rand_space());
				default: begin
					// noise: stray values, class edges, lone signs, separators and underscores, surrogates
					case ($urandom_range(0, 5))
						0: seq.insert(seq.size(), cp_t'($urandom_range(0, 21'h10FFFF)));
						1: seq.insert(seq.size(), rand_edge());
						2: seq.insert(seq.size(), $urandom_range(0, 1) ? CP_PLUS : CP_MINUS);
						3: seq.insert(seq.size(), $urandom_range(0, 1) ? CP_DOT : CP_COMMA);
						4: seq.insert(seq.size(), CP_UNDER);
						default: seq.insert(seq.size(),
							cp_t'($urandom_range(21'h0D800, 21'h0DFFF)));
					endcase
				end
			endcase
			if ($urandom_range(0, 3) == 0)
				seq.insert(seq.size(), rand_space());
		end
		foreach (seq[i])
			push_req(seq[i], i == seq.size() - 1);
		added += seq.size();
	endtask

	task automatic queue_directed();
		push_req(21'h000000, 1'b0);
		push_req(21'h004E00, 1'b0);	// Han run start and continuation
		push_req(21'h009FFF, 1'b0);
		push_req(21'h003400, 1'b0);
		push_req(21'h00FAFF, 1'b0);
		push_req(21'h02FA1F, 1'b0);
		push_req(21'h02A6E0, 1'b0);
		push_req(CP_PLUS, 1'b0);	// signed number, underscore, fraction
		push_req(21'h00FF10, 1'b0);
		push_req(CP_UNDER, 1'b0);
		push_req(21'h000039, 1'b0);
		push_req(CP_DOT, 1'b0);
		push_req(21'h00FF19, 1'b0);
		push_req(CP_COMMA, 1'b0);	// fraction already ends the number
		push_req(CP_MINUS, 1'b0);	// sign with no digit after it
		push_req(21'h000041, 1'b0);
		push_req(21'h00007A, 1'b0);
		push_req(21'h000030, 1'b0);
		push_req(CP_COMMA, 1'b0);	// separator with no digit after it
		push_req(21'h00005A, 1'b0);
		push_req(21'h00D800, 1'b0);
		push_req(21'h10FFFF, 1'b0);
		push_req(21'h000031, 1'b0);
		push_req(CP_DOT, 1'b1);		// held separator at end of text
		push_req(CP_MINUS, 1'b1);	// held sign alone at end of text
	endtask

	initial begin
		int added;
		arst_n           = 1'b0;
		text.valid       = 1'b0;
		text.code_point  = '0;
		text.end_of_text = 1'b0;
		labels.ready     = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin text_gap_pct = 0;  label_stall_pct = 0;  end
				1: begin text_gap_pct = 52; label_stall_pct = 0;  end
				2: begin text_gap_pct = 0;  label_stall_pct = 52; end
				default: begin text_gap_pct = 29; label_stall_pct = 29; end
			endcase
			added = 0;
			if (phase == 0) begin
				queue_directed();
				added = text_reqs.size();
			end
			while (added < PhaseItems)
				queue_text(added);
			while (text_reqs.size() > 0)
				@(posedge clk);
		end

		while (text.valid || due_labels.size() > 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);

		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

[codepoint_token_segmenter.f]
src/cts_pkg.sv
src/cts_in_if.sv
src/cts_out_if.sv
src/codepoint_token_segmenter.sv
tb/tb_codepoint_token_segmenter.sv
